@@ rtl/dnle_pkg.sv @@
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS question name encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int DATA_W    = 8;
    localparam int OFFSET_W  = 9;
    localparam int CAP_W     = 9;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;

    localparam logic [DATA_W-1:0] DOT_CODE = 8'd46;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd2;

    localparam logic [CFG_W-1:0] QUERY_TYPE_RST  = 16'd1;
    localparam logic [CFG_W-1:0] QUERY_CLASS_RST = 16'd1;
    localparam logic [CAP_W-1:0] CAPACITY_RST    = 9'd261;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LABEL_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Request kinds.
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Commands passed from the front part to the back part.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,   // one byte write, checked against the capacity
        OP_REJECT = 2'd1,   // dropped item, reported as is
        OP_END    = 2'd2    // finish the name: length, terminator, type, class
    } op_t;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] write_offset;
        logic [DATA_W-1:0]   write_data;
        logic                last_write;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

@@ rtl/dns_name_label_encoder.sv @@
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Turns a dotted domain name into byte writes of a DNS question.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_item) takes one item per name
//   character, or an end item that closes the name. The output channel
//   (out_valid/out_ready/out_item) gives byte writes (offset, data) that build
//   the question: label length bytes, label bytes, terminator, type, class.
//   Characters are taken one per cycle. A character or dot gives at most one
//   write; an end item gives five or six writes, which the back part emits
//   one per cycle from its output register while the output is not stalled.
//   Each write passes through a four-entry command queue between the front
//   and back parts and then that output register. Characters keep flowing
//   while the back part expands an end item or the receiver stalls; in_ready
//   drops only when that queue is full. Reset empties the queue, clears the
//   name state and loads the register defaults (type 1, class 1, capacity
//   261). Configuration is written through cfg_wr_en/cfg_index/cfg_data by
//   the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int NAME_MAX    = 255,
    parameter int LABEL_MAX   = 63,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Offsets reach the name length plus the five closing bytes.
    localparam int POS_W   = $clog2(NAME_MAX + 6);
    localparam int ENTRY_W = OP_W + 2 * POS_W + DATA_W + STATUS_W;

    logic [CFG_W-1:0]   query_type_reg;
    logic [CFG_W-1:0]   query_class_reg;
    logic [CAP_W-1:0]   capacity_reg;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] head_data;
    logic               head_valid;
    logic               queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_type_reg  <= QUERY_TYPE_RST;
            query_class_reg <= QUERY_CLASS_RST;
            capacity_reg    <= CAPACITY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_QUERY_TYPE:  query_type_reg  <= cfg_data;
                CFG_QUERY_CLASS: query_class_reg <= cfg_data;
                CFG_CAPACITY:    capacity_reg    <= cfg_data[CAP_W-1:0];
                default:         ;
            endcase
        end
    end

    dnle_front #(
        .NAME_MAX  (NAME_MAX),
        .LABEL_MAX (LABEL_MAX),
        .POS_W     (POS_W),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .capacity   (capacity_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    dnle_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    dnle_back #(
        .POS_W   (POS_W),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_data   (head_data),
        .head_valid  (head_valid),
        .pop         (pop),
        .query_type  (query_type_reg),
        .query_class (query_class_reg),
        .capacity    (capacity_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

@@ rtl/dnle_fifo.sv @@
// ----------------------------------------------------------------------------
// dnle_fifo
// Small flop-based command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dnle_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_data = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ rtl/dnle_front.sv @@
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, tracks label and name state, and queues commands.
// ----------------------------------------------------------------------------
module dnle_front
    import dnle_pkg::*;
#(
    parameter int NAME_MAX  = 255,
    parameter int LABEL_MAX = 63,
    parameter int POS_W     = 9,
    parameter int ENTRY_W   = OP_W + 2 * POS_W + DATA_W + STATUS_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    input  logic [CAP_W-1:0]   capacity,
    input  logic               queue_full,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    localparam int LEN_W = $clog2(LABEL_MAX + 1);
    localparam int NC_W  = $clog2(NAME_MAX + 1);
    localparam int CMP_W = (POS_W > CAP_W) ? POS_W : CAP_W;

    typedef struct packed {
        op_t                 op;
        logic [POS_W-1:0]    slot;
        logic [POS_W-1:0]    pos;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
    } entry_t;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    slot_reg, slot_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [NC_W-1:0]     chars_reg, chars_next;

    entry_t entry;
    logic   accept;
    logic   emit;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && emit;
    assign push_data = entry;

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        slot_next  = slot_reg;
        err_next   = err_reg;
        chars_next = chars_reg;
        emit       = 1'b1;
        entry      = '{op: OP_REJECT, slot: '0, pos: pos_reg, data: '0, status: ST_OK};

        if (in_item.req_type == REQ_END)
        begin
            entry = '{op: OP_END, slot: slot_reg, pos: pos_reg,
                      data: DATA_W'(len_reg), status: err_reg};
            pos_next   = POS_W'(1);
            len_next   = '0;
            slot_next  = '0;
            err_next   = ST_OK;
            chars_next = '0;
        end
        else if (chars_reg >= NC_W'(NAME_MAX))
        begin
            entry.status = ST_OVERFLOW;
            if (err_reg == ST_OK)
            begin
                err_next = ST_OVERFLOW;
            end
        end
        else if (in_item.char_code == DOT_CODE)
        begin
            chars_next = chars_reg + 1'b1;
            if (len_reg == '0)
            begin
                // An empty label produces nothing.
                emit = 1'b0;
            end
            else
            begin
                entry = '{op: OP_WRITE, slot: slot_reg, pos: pos_reg,
                          data: DATA_W'(len_reg), status: ST_OK};
                slot_next = pos_reg;
                pos_next  = pos_reg + 1'b1;
                len_next  = '0;
            end
        end
        else if (len_reg >= LEN_W'(LABEL_MAX))
        begin
            entry.status = ST_LABEL_LEN;
            if (err_reg == ST_OK)
            begin
                err_next = ST_LABEL_LEN;
            end
        end
        else if (CMP_W'(pos_reg) >= CMP_W'(capacity))
        begin
            entry.status = ST_OVERFLOW;
            if (err_reg == ST_OK)
            begin
                err_next = ST_OVERFLOW;
            end
        end
        else
        begin
            entry = '{op: OP_WRITE, slot: pos_reg, pos: pos_reg,
                      data: in_item.char_code, status: ST_OK};
            pos_next   = pos_reg + 1'b1;
            len_next   = len_reg + 1'b1;
            chars_next = chars_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_W'(1);
            len_reg   <= '0;
            slot_reg  <= '0;
            err_reg   <= ST_OK;
            chars_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            slot_reg  <= slot_next;
            err_reg   <= err_next;
            chars_reg <= chars_next;
        end
    end

`ifndef SYNTHESIS
    a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LABEL_MAX))
        else $error("label length beyond its limit");
`endif

endmodule

@@ rtl/dnle_back.sv @@
// ----------------------------------------------------------------------------
// dnle_back
// Expands queued commands into byte writes and holds the output register.
// ----------------------------------------------------------------------------
module dnle_back
    import dnle_pkg::*;
#(
    parameter int POS_W   = 9,
    parameter int ENTRY_W = OP_W + 2 * POS_W + DATA_W + STATUS_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRY_W-1:0] head_data,
    input  logic               head_valid,
    output logic               pop,
    input  logic [CFG_W-1:0]   query_type,
    input  logic [CFG_W-1:0]   query_class,
    input  logic [CAP_W-1:0]   capacity,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item
);

    localparam int CMP_W  = (POS_W > CAP_W) ? POS_W : CAP_W;
    localparam int STEP_W = 3;

    typedef struct packed {
        op_t                 op;
        logic [POS_W-1:0]    slot;
        logic [POS_W-1:0]    pos;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
    } entry_t;

    entry_t              head;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg;
    logic                load;
    logic                done;
    logic                checked;
    logic                nonempty;
    logic [1:0]          tail_idx;
    logic [STEP_W-1:0]   tail_step;
    logic [CMP_W-1:0]    offset;
    logic [DATA_W-1:0]   data;
    logic                last;
    logic [STATUS_W-1:0] status;
    out_item_t           gen;

    assign head      = entry_t'(head_data);
    assign load      = !out_valid_reg || out_ready;
    assign nonempty  = (head.data != '0);
    assign tail_step = nonempty ? (step_reg - 3'd2) : (step_reg - 3'd1);
    assign tail_idx  = tail_step[1:0];

    // Byte write for the head command at the current step.
    always_comb
    begin
        offset  = '0;
        data    = '0;
        last    = 1'b0;
        status  = head.status;
        checked = 1'b1;
        done    = 1'b1;
        unique case (head.op)
            OP_WRITE:
            begin
                offset = CMP_W'(head.slot);
                data   = head.data;
            end
            OP_REJECT:
            begin
                checked = 1'b0;
            end
            OP_END:
            begin
                done = 1'b0;
                if (step_reg == '0)
                begin
                    offset = CMP_W'(head.slot);
                    data   = head.data;
                end
                else if (nonempty && step_reg == 3'd1)
                begin
                    offset = CMP_W'(head.pos);
                end
                else
                begin
                    offset = CMP_W'(head.pos) + CMP_W'(nonempty) + CMP_W'(tail_idx);
                    unique case (tail_idx)
                        2'd0: data = query_type[15:8];
                        2'd1: data = query_type[7:0];
                        2'd2: data = query_class[15:8];
                        2'd3: data = query_class[7:0];
                        default: data = '0;
                    endcase
                    last = (tail_idx == 2'd3);
                    done = last;
                end
            end
            default:
            begin
                checked = 1'b0;
            end
        endcase

        // Writes that fall outside the buffer are flagged and blanked.
        if (checked && offset >= CMP_W'(capacity))
        begin
            offset = '0;
            data   = '0;
            status = ST_OVERFLOW;
        end

        gen = '{write_offset: offset[OFFSET_W-1:0], write_data: data,
                last_write: last, status: status};
    end

    always_comb
    begin
        pop            = 1'b0;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                pop       = done;
                step_next = done ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            out_item_reg <= gen;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_step_in_end: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> (head_valid && head.op == OP_END))
        else $error("end expansion step without an end command");
    a_ok_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status == ST_OK) |->
            (CMP_W'(out_item.write_offset) < CMP_W'(capacity)))
        else $error("unflagged write beyond the buffer");
`endif

endmodule

@@ tb/dns_name_label_encoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_tb
// Self-checking bench for the DNS question name encoder. A clocked driver
// feeds name characters and end items from a queue. A clocked monitor
// compares every byte write, field by field, with the writes that a local
// encoder model predicts when each item is accepted. Both sides may idle at
// random. The run covers several register settings, including a zero and a
// full capacity, long receiver stalls, overlong labels and an overlong name.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int NAME_LIMIT     = 255;
    localparam int LABEL_LIMIT    = 63;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_REPORTS    = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_QUERY_TYPE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Register copies and name state of the encoder model.
    logic [CFG_W-1:0]    qtype_m    = QUERY_TYPE_RST;
    logic [CFG_W-1:0]    qclass_m   = QUERY_CLASS_RST;
    int                  cap_m      = int'(CAPACITY_RST);
    int                  wr_pos     = 1;
    int                  lab_len    = 0;
    int                  lab_slot   = 0;
    int                  name_chars = 0;
    logic [STATUS_W-1:0] name_err   = ST_OK;

    in_item_t  pending_items[$];
    out_item_t exp_writes[$];
    int        items_queued = 0;
    int        mismatches   = 0;
    bit        tx_idle_en   = 1'b0;
    bit        rx_idle_en   = 1'b0;
    int        hold_req_cnt = 0;

    dns_name_label_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------
    // Writes at or beyond the capacity come back blanked with overflow status.
    function automatic void queue_write(input int off, input int data, input bit last,
                                        input logic [STATUS_W-1:0] st);
        out_item_t w;
        if (off >= cap_m)
        begin
            st   = ST_OVERFLOW;
            off  = 0;
            data = 0;
        end
        w.write_offset = off[OFFSET_W-1:0];
        w.write_data   = data[DATA_W-1:0];
        w.last_write   = last;
        w.status       = st;
        exp_writes.push_back(w);
    endfunction

    function automatic void queue_reject(input logic [STATUS_W-1:0] code);
        out_item_t w;
        if (name_err == ST_OK)
            name_err = code;
        w        = '0;
        w.status = code;
        exp_writes.push_back(w);
    endfunction

    function automatic void encode_item(input in_item_t it);
        int                  pos;
        logic [STATUS_W-1:0] st;
        if (it.req_type == REQ_CHAR)
        begin
            if (name_chars >= NAME_LIMIT)
                queue_reject(ST_OVERFLOW);
            else if (it.char_code == DOT_CODE)
            begin
                name_chars++;
                // A dot after an empty label produces nothing.
                if (lab_len != 0)
                begin
                    queue_write(lab_slot, lab_len, 1'b0, ST_OK);
                    lab_slot = wr_pos;
                    wr_pos++;
                    lab_len = 0;
                end
            end
            else if (lab_len >= LABEL_LIMIT)
                queue_reject(ST_LABEL_LEN);
            else if (wr_pos >= cap_m)
                queue_reject(ST_OVERFLOW);
            else
            begin
                queue_write(wr_pos, it.char_code, 1'b0, ST_OK);
                wr_pos++;
                lab_len++;
                name_chars++;
            end
        end
        else
        begin
            st  = name_err;
            pos = wr_pos;
            if (lab_len > 0)
            begin
                queue_write(lab_slot, lab_len, 1'b0, st);
                queue_write(pos, 0, 1'b0, st);
                pos++;
            end
            else
                queue_write(lab_slot, 0, 1'b0, st);
            queue_write(pos,     qtype_m[15:8],  1'b0, st);
            queue_write(pos + 1, qtype_m[7:0],   1'b0, st);
            queue_write(pos + 2, qclass_m[15:8], 1'b0, st);
            queue_write(pos + 3, qclass_m[7:0],  1'b1, st);
            wr_pos     = 1;
            lab_len    = 0;
            lab_slot   = 0;
            name_err   = ST_OK;
            name_chars = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_write(input out_item_t got);
        out_item_t want;
        if (exp_writes.size() == 0)
            report_mismatch($sformatf("write offset %0d data %0d with nothing expected",
                                      got.write_offset, got.write_data));
        else
        begin
            want = exp_writes.pop_front();
            if (got.write_offset !== want.write_offset)
                report_mismatch($sformatf("write_offset got %0d expected %0d",
                                          got.write_offset, want.write_offset));
            if (got.write_data !== want.write_data)
                report_mismatch($sformatf("write_data got %0d expected %0d at offset %0d",
                                          got.write_data, want.write_data,
                                          want.write_offset));
            if (got.last_write !== want.last_write)
                report_mismatch($sformatf("last_write got %0b expected %0b at offset %0d",
                                          got.last_write, want.last_write,
                                          want.write_offset));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d expected %0d at offset %0d",
                                          got.status, want.status, want.write_offset));
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_item(in_item);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    gap_left = tx_idle_en ? $urandom_range(0, 8) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int stall_left;
        int hold_left;
        int hold_seen;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_seen  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_write(out_item);
                stall_left = rx_idle_en ? $urandom_range(0, 8) : 0;
            end
            // A new hold request starts a long stall so the block backs up.
            if (hold_seen != hold_req_cnt)
            begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_item(input logic req, input logic [DATA_W-1:0] c);
        pending_items.push_back(in_item_t'{req_type: req, char_code: c});
        items_queued++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(REQ_CHAR, s[i]);
    endfunction

    function automatic void push_end();
        push_item(REQ_END, DATA_W'($urandom_range(0, 255)));
    endfunction

    // Mostly letters, sometimes any byte except the dot.
    function automatic logic [DATA_W-1:0] pick_char();
        int r;
        if ($urandom_range(0, 3) != 0)
            return DATA_W'($urandom_range(97, 122));
        r = $urandom_range(0, 255);
        if (r == DOT_CODE)
            r = 47;
        return DATA_W'(r);
    endfunction

    function automatic void push_label(input int len);
        for (int i = 0; i < len; i++)
            push_item(REQ_CHAR, pick_char());
    endfunction

    function automatic void queue_random_name();
        int kind;
        int labels;
        int r;
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            // Noise: loose characters, dots and ends in any order.
            labels = $urandom_range(1, 12);
            for (int i = 0; i < labels; i++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    push_end();
                else if (r < 4)
                    push_item(REQ_CHAR, DOT_CODE);
                else
                    push_item(REQ_CHAR, pick_char());
            end
        end
        else if (kind == 2)
        begin
            push_label($urandom_range(60, 70));
            push_item(REQ_CHAR, DOT_CODE);
            push_label($urandom_range(1, 5));
            push_end();
        end
        else
        begin
            labels = $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0)
                push_item(REQ_CHAR, DOT_CODE);
            for (int i = 0; i < labels; i++)
            begin
                push_label($urandom_range(1, 12));
                if (i < labels - 1 || $urandom_range(0, 9) == 0)
                    push_item(REQ_CHAR, DOT_CODE);
                if ($urandom_range(0, 14) == 0)
                    push_item(REQ_CHAR, DOT_CODE);
            end
            push_end();
        end
    endfunction

    function automatic void run_random(input int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
            queue_random_name();
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_QUERY_TYPE:  qtype_m  = val;
            CFG_QUERY_CLASS: qclass_m = val;
            CFG_CAPACITY:    cap_m    = int'(val[CAP_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] qtype, input logic [CFG_W-1:0] qclass,
                            input int cap);
        write_reg(CFG_QUERY_TYPE, qtype);
        write_reg(CFG_QUERY_CLASS, qclass);
        write_reg(CFG_CAPACITY, CFG_W'(cap));
    endtask

    // The sender stays quiet until every expected write has come back; a dot
    // that produces nothing may still be in flight, hence the extra cycles.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((pending_items.size() != 0 || in_valid || exp_writes.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme bytes, a skipped empty label, an empty name, a name that
        // is only a dot, and a name with a trailing dot.
        push_item(REQ_CHAR, 8'h00);
        push_item(REQ_CHAR, 8'hFF);
        push_text("..x");
        push_end();
        push_end();
        push_text(".");
        push_end();
        push_text("ab.");
        push_end();
        wait_drained();

        // A tiny buffer: late characters are dropped, end writes are flagged
        // and the earlier error is carried into the end writes.
        write_reg(CFG_CAPACITY, CFG_W'(4));
        @(negedge clk);
        push_text("abcdef");
        push_end();
        wait_drained();

        set_regs(16'hFFFF, 16'h0000, int'(CAPACITY_RST));
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        @(negedge clk);
        // Every label is one character too long. The name then reaches its
        // limit, so the last extra character, the dot and the short label
        // after it are dropped as well.
        for (int i = 0; i < 4; i++)
        begin
            push_label(LABEL_LIMIT + 1);
            push_item(REQ_CHAR, DOT_CODE);
        end
        push_label(2);
        push_end();
        run_random(12);
        @(posedge clk);
        hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();

        set_regs(16'h0000, 16'hFFFF, 0);
        @(negedge clk);
        run_random(10);
        wait_drained();

        set_regs(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                 $urandom_range(6, 40));
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        @(negedge clk);
        run_random(12);
        @(posedge clk);
        hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();

        set_regs(16'hA55A, 16'h5AA5, int'(CAPACITY_RST));
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        @(negedge clk);
        run_random(12);
        @(posedge clk);
        hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();

        if (exp_writes.size() != 0)
            report_mismatch($sformatf("%0d expected writes never arrived", exp_writes.size()));
        if (mismatches == 0)
            $display("PASS dns_name_label_encoder");
        else
            $display("FAIL dns_name_label_encoder");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL dns_name_label_encoder");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dnle_pkg.sv
rtl/dnle_fifo.sv
rtl/dnle_front.sv
rtl/dnle_back.sv
rtl/dns_name_label_encoder.sv
tb/dns_name_label_encoder_tb.sv
